FILE: hw/rtl/mhpc_pkg.sv
package mhpc_pkg;

   localparam int PITCH_CLASSES = 12;
   localparam int COUNT_WIDTH   = 8;
   localparam int PC_WIDTH      = $clog2(PITCH_CLASSES);
   localparam int CSR_IDX_WIDTH = 2;
   localparam int CSR_DATA_WIDTH = 12;

   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};
   localparam logic [PITCH_CLASSES-1:0] MASK_ALL = 12'hfff;

   // register indexes
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_NOTE_SOURCE     = 2'd0;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_CHANNEL_SELECT  = 2'd1;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_FIXED_NOTE_MASK = 2'd2;

   // MIDI codes
   localparam logic [7:0] TYPE_MASK      = 8'hf0;
   localparam logic [7:0] CHAN_MASK      = 8'h0f;
   localparam logic [7:0] TYPE_CTRL      = 8'hb0;
   localparam logic [7:0] TYPE_NOTE_ON   = 8'h90;
   localparam logic [7:0] TYPE_NOTE_OFF  = 8'h80;
   localparam logic [7:0] CC_ALL_NOTES_OFF = 8'd123;
   localparam logic [7:0] CC_ALL_SOUND_OFF = 8'd120;
   localparam logic [7:0] MSG_LEN_FULL   = 8'd3;

   typedef enum logic [1:0] {
      MODE_AUTO  = 2'd0,
      MODE_HELD  = 2'd1,
      MODE_FIXED = 2'd2,
      MODE_FIXED_ALT = 2'd3
   } note_source_type;

   typedef logic [COUNT_WIDTH-1:0] count_type;

   // note number modulo 12: reciprocal multiply, exact for 8-bit inputs
   function automatic logic [PC_WIDTH-1:0] pitch_class(input logic [7:0] note);
      logic [15:0] prod;
      logic [4:0]  quot;
      logic [7:0]  rem;
      prod = 16'(note) * 16'd171;
      quot = prod[15:11];
      rem  = note - (8'(quot) * 8'd12);
      return rem[PC_WIDTH-1:0];
   endfunction

endpackage

FILE: hw/rtl/midi_held_pitch_class_tracker_core.sv
// Channel | Direction | Handshake           | Payload
// req     | in        | req_valid/req_stall | status, two data bytes, length, panic
// rsp     | out       | rsp_valid/rsp_stall | held mask, effective mask, changed
// csr     | in        | csr_wr_en           | csr_index, csr_wdata
//
// One request per cycle sustained while rsp is not stalled; each result passes
// through the input register, then the count update into the result register.
// The twelve counters update in the same cycle the result is formed.
// Synchronous active-high reset clears the counters, the pipeline valids and
// restores register defaults. A stall on rsp holds the result register and
// backs up into req_stall only once the input register is also full.
module midi_held_pitch_class_tracker_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_status_byte,
   input  logic [7:0]  req_data_one,
   input  logic [7:0]  req_data_two,
   input  logic [7:0]  req_message_length,
   input  logic        req_panic,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [11:0] rsp_held_mask,
   output logic [11:0] rsp_effective_mask,
   output logic        rsp_changed,
   input  logic        csr_wr_en,
   input  logic [mhpc_pkg::CSR_IDX_WIDTH-1:0]  csr_index,
   input  logic [mhpc_pkg::CSR_DATA_WIDTH-1:0] csr_wdata
);

   localparam int N = mhpc_pkg::PITCH_CLASSES;

   // configuration
   mhpc_pkg::note_source_type note_source_ff;
   logic [4:0]   channel_select_ff;
   logic [N-1:0] fixed_mask_ff;

   // input register
   logic       s1_valid_ff;
   logic [7:0] s1_status_ff, s1_data_one_ff, s1_data_two_ff, s1_length_ff;
   logic       s1_panic_ff;

   // held counts
   mhpc_pkg::count_type counts_ff [N];
   mhpc_pkg::count_type counts_in [N];

   // result register
   logic         rsp_valid_ff;
   logic [N-1:0] held_ff, eff_ff;
   logic         changed_ff;
   logic [N-1:0] held_in, eff_in;
   logic         changed_in;

   logic req_accept, s1_adv;

   // advance the input register whenever the result register is free to load
   assign s1_adv     = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall  = s1_valid_ff && !s1_adv;
   assign req_accept = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         note_source_ff    <= mhpc_pkg::MODE_AUTO;
         channel_select_ff <= 5'd0;
         fixed_mask_ff     <= mhpc_pkg::MASK_ALL;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            mhpc_pkg::CSR_NOTE_SOURCE:
               note_source_ff <= mhpc_pkg::note_source_type'(csr_wdata[1:0]);
            mhpc_pkg::CSR_CHANNEL_SELECT: channel_select_ff <= csr_wdata[4:0];
            mhpc_pkg::CSR_FIXED_NOTE_MASK: fixed_mask_ff <= csr_wdata[N-1:0];
            default: ; // drop writes beyond the register list
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_accept) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_adv) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_status_ff   <= req_status_byte;
         s1_data_one_ff <= req_data_one;
         s1_data_two_ff <= req_data_two;
         s1_length_ff   <= req_message_length;
         s1_panic_ff    <= req_panic;
      end
   end

   // message decode and count update
   logic                               fixed_mode, pre_clear, chan_ok, act;
   logic                               is_ctrl, ctrl_clear, note_inc, note_dec;
   logic [mhpc_pkg::PC_WIDTH-1:0]      pc;
   logic [3:0]                         chan_want;
   mhpc_pkg::count_type                base;

   always_comb begin
      fixed_mode = (note_source_ff == mhpc_pkg::MODE_FIXED) ||
                   (note_source_ff == mhpc_pkg::MODE_FIXED_ALT);
      pre_clear  = s1_panic_ff || fixed_mode;
      chan_want  = 4'(channel_select_ff - 5'd1);
      chan_ok    = (channel_select_ff == 5'd0) || (channel_select_ff > 5'd16) ||
                   ((s1_status_ff & mhpc_pkg::CHAN_MASK) == {4'd0, chan_want});
      act        = (s1_length_ff == mhpc_pkg::MSG_LEN_FULL) && chan_ok;
      pc         = mhpc_pkg::pitch_class(s1_data_one_ff);
      is_ctrl    = (s1_status_ff & mhpc_pkg::TYPE_MASK) == mhpc_pkg::TYPE_CTRL;
      ctrl_clear = act && is_ctrl && (s1_data_two_ff == 8'd0) &&
                   ((s1_data_one_ff == mhpc_pkg::CC_ALL_NOTES_OFF) ||
                    (s1_data_one_ff == mhpc_pkg::CC_ALL_SOUND_OFF));
      note_inc   = act && ((s1_status_ff & mhpc_pkg::TYPE_MASK) == mhpc_pkg::TYPE_NOTE_ON) &&
                   (s1_data_two_ff != 8'd0);
      note_dec   = act && !note_inc &&
                   (((s1_status_ff & mhpc_pkg::TYPE_MASK) == mhpc_pkg::TYPE_NOTE_ON) ||
                    ((s1_status_ff & mhpc_pkg::TYPE_MASK) == mhpc_pkg::TYPE_NOTE_OFF));

      changed_in = 1'b0;
      for (int i = 0; i < N; i++) begin
         base = pre_clear ? '0 : counts_ff[i];
         counts_in[i] = base;
         if (ctrl_clear) begin
            counts_in[i] = '0;
         end else if (pc == mhpc_pkg::PC_WIDTH'(i)) begin
            // saturate at the top, hold at zero
            if (note_inc && base != mhpc_pkg::COUNT_MAX) begin
               counts_in[i] = base + 1'b1;
               changed_in   = 1'b1;
            end else if (note_dec && base != '0) begin
               counts_in[i] = base - 1'b1;
               changed_in   = 1'b1;
            end
         end
         held_in[i] = counts_in[i] != '0;
      end

      case (note_source_ff)
         mhpc_pkg::MODE_HELD: eff_in = held_in;
         mhpc_pkg::MODE_AUTO: eff_in = (held_in != '0) ? held_in : fixed_mask_ff;
         default:             eff_in = fixed_mask_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < N; i++) begin
            counts_ff[i] <= '0;
         end
      end else if (s1_adv) begin
         for (int i = 0; i < N; i++) begin
            counts_ff[i] <= counts_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_adv) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         held_ff    <= held_in;
         eff_ff     <= eff_in;
         changed_ff <= changed_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_held_mask      = held_ff;
   assign rsp_effective_mask = eff_ff;
   assign rsp_changed        = changed_ff;

endmodule

FILE: hw/rtl/mhpc_checker.sv
module mhpc_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [11:0] rsp_held_mask,
   input logic [11:0] rsp_effective_mask,
   input logic        rsp_changed
);

   // no result right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_held_mask) &&
         $stable(rsp_effective_mask) && $stable(rsp_changed)))
      else $error("stalled result changed");

   // back-pressure only with a waiting result
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid)
      else $error("request stalled with empty output");

   // request into an empty output comes out through the input and result registers
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && !rsp_valid) |=> ##1 rsp_valid)
      else $error("result missing after accepted request");

endmodule

bind midi_held_pitch_class_tracker_core mhpc_checker u_mhpc_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_valid),
   .req_stall          (req_stall),
   .rsp_valid          (rsp_valid),
   .rsp_stall          (rsp_stall),
   .rsp_held_mask      (rsp_held_mask),
   .rsp_effective_mask (rsp_effective_mask),
   .rsp_changed        (rsp_changed)
);

FILE: sim/tb.sv
`timescale 1ns / 1ps

module tb;

   localparam logic [mhpc_pkg::CSR_IDX_WIDTH-1:0] CSR_UNUSED = 2'd3;
   localparam int NUM_PHASES       = 9;
   localparam int SATURATION_PHASE = 3;
   localparam int NUM_OPENING      = 23;
   localparam int SETTLE_CYCLES    = 4;

   typedef struct packed {
      logic [7:0] status_byte;
      logic [7:0] data_one;
      logic [7:0] data_two;
      logic [7:0] message_length;
      logic       panic;
   } midi_request_type;

   typedef struct packed {
      logic [11:0] held_mask;
      logic [11:0] effective_mask;
      logic        changed;
   } mask_result_type;

   // typed = 1: the row carries its own expected masks
   typedef struct packed {
      logic            typed;
      mask_result_type res;
   } check_tag_type;

   typedef struct packed {
      logic [7:0]  status_byte;
      logic [7:0]  data_one;
      logic [7:0]  data_two;
      logic [7:0]  message_length;
      logic        panic;
      logic        typed;
      logic [11:0] held_mask;
      logic [11:0] effective_mask;
      logic        changed;
   } opening_row_type;

   // Opening rows, run at reset settings: auto mode, every channel, fixed mask all ones.
   localparam opening_row_type OPENING_ROWS [NUM_OPENING] = '{
      // note-off on an empty class
      '{mhpc_pkg::TYPE_NOTE_OFF, 8'h3c, 8'h00, mhpc_pkg::MSG_LEN_FULL, 1'b0, 1'b1,
        12'h000, 12'hfff, 1'b0},
      '{mhpc_pkg::TYPE_NOTE_ON, 8'h3c, 8'h64, mhpc_pkg::MSG_LEN_FULL, 1'b0, 1'b1,
        12'h001, 12'h001, 1'b1},
      // all-ones bytes: class 3, top channel, top velocity
      '{mhpc_pkg::TYPE_NOTE_ON | 8'h0f, 8'hff, 8'hff, mhpc_pkg::MSG_LEN_FULL, 1'b0, 1'b1,
        12'h009, 12'h009, 1'b1},
      '{mhpc_pkg::TYPE_NOTE_ON, 8'h48, 8'h01, mhpc_pkg::MSG_LEN_FULL, 1'b0, 1'b0,
        12'h000, 12'h000, 1'b0},
      // note-on with zero velocity acts as note-off
      '{mhpc_pkg::TYPE_NOTE_ON, 8'h3c, 8'h00, mhpc_pkg::MSG_LEN_FULL, 1'b0, 1'b0,
        12'h000, 12'h000, 1'b0},
      '{mhpc_pkg::TYPE_NOTE_OFF, 8'h00, 8'h7f, mhpc_pkg::MSG_LEN_FULL, 1'b0, 1'b0,
        12'h000, 12'h000, 1'b0},
      '{mhpc_pkg::TYPE_NOTE_OFF, 8'h00, 8'h7f, mhpc_pkg::MSG_LEN_FULL, 1'b0, 1'b1,
        12'h008, 12'h008, 1'b0},
      // short, empty and oversized lengths are ignored
      '{mhpc_pkg::TYPE_NOTE_ON, 8'h05, 8'h40, 8'd2, 1'b0, 1'b1, 12'h008, 12'h008, 1'b0},
      '{mhpc_pkg::TYPE_NOTE_ON, 8'h05, 8'h40, 8'd0, 1'b0, 1'b1, 12'h008, 12'h008, 1'b0},
      '{mhpc_pkg::TYPE_NOTE_ON, 8'h05, 8'h40, 8'hff, 1'b0, 1'b1, 12'h008, 12'h008, 1'b0},
      // poly aftertouch is not a note message
      '{8'ha0, 8'h05, 8'h40, mhpc_pkg::MSG_LEN_FULL, 1'b0, 1'b1, 12'h008, 12'h008, 1'b0},
      // all-notes-off with nonzero value, and a neighbor controller, do not clear
      '{mhpc_pkg::TYPE_CTRL, mhpc_pkg::CC_ALL_NOTES_OFF, 8'h01, mhpc_pkg::MSG_LEN_FULL,
        1'b0, 1'b1, 12'h008, 12'h008, 1'b0},
      '{mhpc_pkg::TYPE_CTRL, 8'd121, 8'h00, mhpc_pkg::MSG_LEN_FULL, 1'b0, 1'b1,
        12'h008, 12'h008, 1'b0},
      '{mhpc_pkg::TYPE_NOTE_ON | 8'h01, 8'h0b, 8'h0a, mhpc_pkg::MSG_LEN_FULL, 1'b0, 1'b1,
        12'h808, 12'h808, 1'b1},
      '{mhpc_pkg::TYPE_CTRL | 8'h05, mhpc_pkg::CC_ALL_SOUND_OFF, 8'h00,
        mhpc_pkg::MSG_LEN_FULL, 1'b0, 1'b1, 12'h000, 12'hfff, 1'b0},
      '{mhpc_pkg::TYPE_NOTE_ON, 8'h07, 8'h40, mhpc_pkg::MSG_LEN_FULL, 1'b0, 1'b1,
        12'h080, 12'h080, 1'b1},
      '{mhpc_pkg::TYPE_CTRL | 8'h0f, mhpc_pkg::CC_ALL_NOTES_OFF, 8'h00,
        mhpc_pkg::MSG_LEN_FULL, 1'b0, 1'b1, 12'h000, 12'hfff, 1'b0},
      // note number above 127 wraps to class 8
      '{mhpc_pkg::TYPE_NOTE_ON, 8'h80, 8'hc8, mhpc_pkg::MSG_LEN_FULL, 1'b0, 1'b1,
        12'h100, 12'h100, 1'b1},
      // panic clears before the note lands
      '{mhpc_pkg::TYPE_NOTE_ON, 8'h02, 8'h32, mhpc_pkg::MSG_LEN_FULL, 1'b1, 1'b1,
        12'h004, 12'h004, 1'b1},
      '{8'h00, 8'h00, 8'h00, 8'd0, 1'b1, 1'b1, 12'h000, 12'hfff, 1'b0},
      '{mhpc_pkg::TYPE_NOTE_OFF, 8'h02, 8'h00, mhpc_pkg::MSG_LEN_FULL, 1'b1, 1'b1,
        12'h000, 12'hfff, 1'b0},
      '{8'hff, 8'hff, 8'hff, mhpc_pkg::MSG_LEN_FULL, 1'b0, 1'b1, 12'h000, 12'hfff, 1'b0},
      '{mhpc_pkg::TYPE_NOTE_ON | 8'h0a, 8'h7f, 8'h7f, mhpc_pkg::MSG_LEN_FULL, 1'b0, 1'b0,
        12'h000, 12'h000, 1'b0}
   };

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_status_byte = '0;
   logic [7:0]  req_data_one = '0;
   logic [7:0]  req_data_two = '0;
   logic [7:0]  req_message_length = '0;
   logic        req_panic = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [11:0] rsp_held_mask;
   logic [11:0] rsp_effective_mask;
   logic        rsp_changed;
   logic        csr_wr_en = 1'b0;
   logic [mhpc_pkg::CSR_IDX_WIDTH-1:0]  csr_index = '0;
   logic [mhpc_pkg::CSR_DATA_WIDTH-1:0] csr_wdata = '0;

   // predictor copy of the block's state and registers
   mhpc_pkg::count_type       class_counts [mhpc_pkg::PITCH_CLASSES];
   mhpc_pkg::note_source_type src_setting;
   logic [4:0]                chan_setting;
   logic [11:0]               fixed_setting;

   mask_result_type mask_results [$];
   check_tag_type   row_checks [$];
   int              mismatches = 0;
   int              sender_gap_pct = 0;
   int              receiver_stall_pct = 0;
   int              cur_chan = 0;

   midi_held_pitch_class_tracker_core uut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_status_byte    (req_status_byte),
      .req_data_one       (req_data_one),
      .req_data_two       (req_data_two),
      .req_message_length (req_message_length),
      .req_panic          (req_panic),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_held_mask      (rsp_held_mask),
      .rsp_effective_mask (rsp_effective_mask),
      .rsp_changed        (rsp_changed),
      .csr_wr_en          (csr_wr_en),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic void clear_counts();
      foreach (class_counts[i]) class_counts[i] = '0;
   endfunction

   function automatic mask_result_type track_message(input midi_request_type rq);
      mask_result_type           r;
      mhpc_pkg::note_source_type mode;
      logic [3:0]                pc;
      logic [7:0]                kind;
      logic [11:0]               held;
      logic                      in_channel;
      r.changed = 1'b0;
      mode = (src_setting == mhpc_pkg::MODE_FIXED_ALT) ? mhpc_pkg::MODE_FIXED : src_setting;
      if (rq.panic || mode == mhpc_pkg::MODE_FIXED) clear_counts();
      in_channel = (chan_setting == 5'd0 || chan_setting > 5'd16) ||
                   (rq.status_byte[3:0] == 4'(chan_setting - 5'd1));
      kind = rq.status_byte & mhpc_pkg::TYPE_MASK;
      pc = 4'(rq.data_one % 8'd12);
      if (rq.message_length == mhpc_pkg::MSG_LEN_FULL && in_channel) begin
         if (kind == mhpc_pkg::TYPE_CTRL) begin
            if ((rq.data_one == mhpc_pkg::CC_ALL_NOTES_OFF ||
                 rq.data_one == mhpc_pkg::CC_ALL_SOUND_OFF) && rq.data_two == 8'd0)
               clear_counts();
         end else if (kind == mhpc_pkg::TYPE_NOTE_ON && rq.data_two != 8'd0) begin
            if (class_counts[pc] != mhpc_pkg::COUNT_MAX) begin
               class_counts[pc] = class_counts[pc] + 1'b1;
               r.changed = 1'b1;
            end
         end else if (kind == mhpc_pkg::TYPE_NOTE_ON || kind == mhpc_pkg::TYPE_NOTE_OFF) begin
            if (class_counts[pc] != '0) begin
               class_counts[pc] = class_counts[pc] - 1'b1;
               r.changed = 1'b1;
            end
         end
      end
      held = '0;
      foreach (class_counts[i]) if (class_counts[i] != '0) held[i] = 1'b1;
      r.held_mask = held;
      if (mode == mhpc_pkg::MODE_HELD) r.effective_mask = held;
      else if (mode == mhpc_pkg::MODE_FIXED) r.effective_mask = fixed_setting;
      else r.effective_mask = (held != '0) ? held : fixed_setting;
      return r;
   endfunction

   // Predict on accepted requests, check accepted results against the oldest prediction.
   always @(posedge clock) begin : scoreboard
      midi_request_type rq;
      mask_result_type  want;
      check_tag_type    tag;
      if (reset) begin
         clear_counts();
         src_setting   = mhpc_pkg::MODE_AUTO;
         chan_setting  = 5'd0;
         fixed_setting = mhpc_pkg::MASK_ALL;
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               mhpc_pkg::CSR_NOTE_SOURCE:
                  src_setting = mhpc_pkg::note_source_type'(csr_wdata[1:0]);
               mhpc_pkg::CSR_CHANNEL_SELECT:  chan_setting = csr_wdata[4:0];
               mhpc_pkg::CSR_FIXED_NOTE_MASK: fixed_setting = csr_wdata[11:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            rq = '{req_status_byte, req_data_one, req_data_two, req_message_length, req_panic};
            want = track_message(rq);
            tag = row_checks.pop_front();
            if (tag.typed) want = tag.res;
            mask_results.push_back(want);
         end
         if (rsp_valid && !rsp_stall) begin
            if (mask_results.size() == 0) begin
               $error("result with no request outstanding: held_mask %03h", rsp_held_mask);
               mismatches++;
            end else begin
               want = mask_results.pop_front();
               if (rsp_held_mask !== want.held_mask) begin
                  $error("held_mask: expected %03h, actual %03h", want.held_mask, rsp_held_mask);
                  mismatches++;
               end
               if (rsp_effective_mask !== want.effective_mask) begin
                  $error("effective_mask: expected %03h, actual %03h",
                         want.effective_mask, rsp_effective_mask);
                  mismatches++;
               end
               if (rsp_changed !== want.changed) begin
                  $error("changed: expected %0b, actual %0b", want.changed, rsp_changed);
                  mismatches++;
               end
            end
         end
      end
   end

   always @(posedge clock) rsp_stall <= ($urandom_range(99) < receiver_stall_pct);

   // Hold the request until accepted; insert random gaps before it.
   task automatic send_message(input midi_request_type rq, input check_tag_type tag);
      while ($urandom_range(99) < sender_gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      row_checks.push_back(tag);
      req_valid          <= 1'b1;
      req_status_byte    <= rq.status_byte;
      req_data_one       <= rq.data_one;
      req_data_two       <= rq.data_two;
      req_message_length <= rq.message_length;
      req_panic          <= rq.panic;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // Drop valid and wait for every outstanding result, then let the pipe drain.
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (mask_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Unused bits of the write data carry noise.
   task automatic write_reg(input logic [mhpc_pkg::CSR_IDX_WIDTH-1:0] idx,
                            input logic [mhpc_pkg::CSR_DATA_WIDTH-1:0] value,
                            input logic [mhpc_pkg::CSR_DATA_WIDTH-1:0] used_bits);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= (value & used_bits) | (12'($urandom) & ~used_bits);
      @(posedge clock);
   endtask

   task automatic configure(input mhpc_pkg::note_source_type src, input logic [4:0] chan,
                            input logic [11:0] mask);
      settle();
      write_reg(mhpc_pkg::CSR_NOTE_SOURCE, 12'(src), 12'h003);
      write_reg(mhpc_pkg::CSR_CHANNEL_SELECT, 12'(chan), 12'h01f);
      write_reg(mhpc_pkg::CSR_FIXED_NOTE_MASK, mask, 12'hfff);
      // a write to the spare index must not disturb any register
      write_reg(CSR_UNUSED, 12'($urandom), 12'hfff);
      csr_wr_en <= 1'b0;
      cur_chan = chan;
   endtask

   // Mostly well-formed note traffic on the selected channel, some clears, some noise.
   function automatic midi_request_type random_message();
      midi_request_type rq;
      int               kind;
      logic [7:0]       nib;
      kind = $urandom_range(99);
      if (cur_chan >= 1 && cur_chan <= 16 && $urandom_range(3) != 0)
         nib = 8'(cur_chan - 1);
      else
         nib = 8'($urandom_range(15));
      rq.message_length = mhpc_pkg::MSG_LEN_FULL;
      rq.panic = ($urandom_range(99) < 3);
      rq.data_one = ($urandom_range(7) == 0) ? 8'($urandom) : 8'($urandom_range(127));
      rq.data_two = ($urandom_range(7) == 0) ? 8'($urandom_range(255, 128))
                                             : 8'($urandom_range(127, 1));
      if (kind < 45) begin
         rq.status_byte = mhpc_pkg::TYPE_NOTE_ON | nib;
      end else if (kind < 80) begin
         if ($urandom_range(1) == 0) begin
            rq.status_byte = mhpc_pkg::TYPE_NOTE_OFF | nib;
            rq.data_two = 8'($urandom);
         end else begin
            rq.status_byte = mhpc_pkg::TYPE_NOTE_ON | nib;
            rq.data_two = 8'h00;
         end
      end else if (kind < 85) begin
         rq.status_byte = mhpc_pkg::TYPE_CTRL | nib;
         rq.data_one = ($urandom_range(1) == 0) ? mhpc_pkg::CC_ALL_NOTES_OFF
                                                : mhpc_pkg::CC_ALL_SOUND_OFF;
         rq.data_two = ($urandom_range(3) == 0) ? 8'($urandom_range(255, 1)) : 8'h00;
      end else if (kind < 90) begin
         rq.status_byte = {4'($urandom), nib[3:0]};
      end else if (kind < 95) begin
         rq.status_byte = (($urandom_range(1) == 0) ? mhpc_pkg::TYPE_NOTE_ON
                                                    : mhpc_pkg::TYPE_NOTE_OFF) | nib;
         do rq.message_length = 8'($urandom);
         while (rq.message_length == mhpc_pkg::MSG_LEN_FULL);
      end else begin
         rq.status_byte    = 8'($urandom);
         rq.data_one       = 8'($urandom);
         rq.data_two       = 8'($urandom);
         rq.message_length = 8'($urandom);
         rq.panic          = 1'($urandom);
      end
      return rq;
   endfunction

   initial begin : stimulus
      midi_request_type rq;
      check_tag_type    tag;
      check_tag_type    no_tag;
      int               p;
      int               k;
      int               n_random;
      no_tag = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      for (p = 0; p < NUM_PHASES; p++) begin
         if (p < 3) begin
            sender_gap_pct = 19;
            receiver_stall_pct = 45;
         end else if (p < 6) begin
            sender_gap_pct = 45;
            receiver_stall_pct = 19;
         end else begin
            sender_gap_pct = 0;
            receiver_stall_pct = 0;
         end
         case (p)
            0: ;  // stay at reset settings
            1: configure(mhpc_pkg::MODE_HELD, 5'd0, 12'h000);
            2: configure(mhpc_pkg::MODE_FIXED, 5'd16, 12'hfff);
            3: configure(mhpc_pkg::MODE_AUTO, 5'd0, 12'h0f0);
            4: configure(mhpc_pkg::MODE_FIXED_ALT, 5'd1, 12'h555);
            5: configure(mhpc_pkg::MODE_AUTO, 5'd17, 12'haaa);
            6: configure(mhpc_pkg::MODE_HELD, 5'd31, 12'($urandom));
            7: configure(mhpc_pkg::MODE_AUTO, 5'($urandom_range(16, 1)), 12'($urandom));
            default: configure(mhpc_pkg::MODE_AUTO, 5'd0, 12'h000);
         endcase
         if (p == 0) begin
            for (k = 0; k < NUM_OPENING; k++) begin
               rq = '{OPENING_ROWS[k].status_byte, OPENING_ROWS[k].data_one,
                      OPENING_ROWS[k].data_two, OPENING_ROWS[k].message_length,
                      OPENING_ROWS[k].panic};
               tag = '{OPENING_ROWS[k].typed,
                       '{OPENING_ROWS[k].held_mask, OPENING_ROWS[k].effective_mask,
                         OPENING_ROWS[k].changed}};
               send_message(rq, tag);
            end
         end
         if (p == SATURATION_PHASE) begin
            // drive one class past its counter limit, then walk it back a little
            for (k = 0; k < 270; k++) begin
               rq.status_byte    = mhpc_pkg::TYPE_NOTE_ON | 8'($urandom_range(15));
               rq.data_one       = 8'(5 + 12 * $urandom_range(19));
               rq.data_two       = 8'($urandom_range(255, 1));
               rq.message_length = mhpc_pkg::MSG_LEN_FULL;
               rq.panic          = 1'b0;
               send_message(rq, no_tag);
            end
            for (k = 0; k < 20; k++) begin
               rq.status_byte = mhpc_pkg::TYPE_NOTE_OFF | 8'($urandom_range(15));
               rq.data_one    = 8'(5 + 12 * $urandom_range(19));
               rq.data_two    = 8'($urandom);
               send_message(rq, no_tag);
            end
         end
         n_random = (p == 0) ? 150 : ((p == SATURATION_PHASE) ? 80 : 180);
         for (k = 0; k < n_random; k++) send_message(random_message(), no_tag);
      end
      settle();
      if (mismatches == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

   initial begin : watchdog
      #2_000_000;
      $display("TB_ERROR");
      $finish;
   end

endmodule
